FILE: hw/rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
// Used by brf_ctrl and byte_ring_fifo_unit; depends on nothing.
`timescale 1ns / 1ps

package brf_pkg;

    localparam int CAP_W = 7;   // capacity register and internal counts
    localparam int REQ_W = 6;   // request count field
    localparam int CNT_W = 6;   // count fields of a result beat

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic [CAP_W-1:0] CAP_MIN   = 7'd2;

    // One result beat, less the byte itself, which comes from the store.
    typedef struct packed {
        logic             is_data;
        logic             last;
        logic [CNT_W-1:0] moved;
        logic [1:0]       status;
        logic [CNT_W-1:0] stored;
        logic [CNT_W-1:0] free;
    } brf_beat_t;

endpackage

FILE: hw/rtl/brf_mem.sv
// Byte store: one write port and one read port, read data registered.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module brf_mem #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/brf_ctrl.sv
// Pointer state, burst staging, read sequencer and result beat register.
// Depends on brf_pkg; drives the byte store in brf_mem.
`timescale 1ns / 1ps

module brf_ctrl
    import brf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [CAP_W-1:0]         cap,
    input  logic                     clr,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_burst_last,
    input  logic [REQ_W-1:0]         s_request_count,
    output logic                     m_valid,
    input  logic                     m_ready,
    output brf_beat_t                beat,
    output logic                     mem_wr_en,
    output logic [$clog2(DEPTH)-1:0] mem_wr_addr,
    output logic [7:0]               mem_wr_data,
    output logic                     mem_rd_en,
    output logic [$clog2(DEPTH)-1:0] mem_rd_addr
);

    localparam int AW    = $clog2(DEPTH);
    localparam int PTR_W = (AW < CAP_W) ? AW : CAP_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic             state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] bp_reg, bp_next;
    logic [CAP_W-1:0] blen_reg, blen_next;
    logic             ovf_reg, ovf_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [REQ_W-1:0] remain_reg, remain_next;
    logic             out_valid_reg, out_valid_next;
    brf_beat_t        beat_reg, beat_next;

    logic             accept;
    logic             out_free;
    logic [CAP_W-1:0] have;
    logic [CAP_W-1:0] free_now;
    logic [CAP_W-1:0] n_rd;
    logic [CAP_W:0]   rp_sum;
    logic [PTR_W-1:0] rp_adv;
    logic [PTR_W-1:0] bp_eff;
    logic [PTR_W-1:0] bp_w;
    logic [CAP_W-1:0] blen_w;
    logic             ovf_w;
    logic [CAP_W-1:0] stored_after;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [CAP_W-1:0] c);
        logic [CAP_W:0] s;
        s = (CAP_W+1)'(p) + 1'b1;
        return (s >= {1'b0, c}) ? '0 : PTR_W'(s);
    endfunction

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign have = (wp_reg >= rp_reg) ? (CAP_W'(wp_reg) - CAP_W'(rp_reg))
                                     : (cap - (CAP_W'(rp_reg) - CAP_W'(wp_reg)));
    assign free_now = cap - 1'b1 - have;

    assign n_rd   = (CAP_W'(s_request_count) < have) ? CAP_W'(s_request_count) : have;
    assign rp_sum = ((CAP_W+1)'(rp_reg) + (CAP_W+1)'(n_rd) >= {1'b0, cap})
                  ? ((CAP_W+1)'(rp_reg) + (CAP_W+1)'(n_rd) - {1'b0, cap})
                  : ((CAP_W+1)'(rp_reg) + (CAP_W+1)'(n_rd));
    assign rp_adv = adv(rp_reg, cap);
    assign bp_eff = (blen_reg == '0) ? wp_reg : bp_reg;

    always_comb begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        bp_next        = bp_reg;
        blen_next      = blen_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        remain_next    = remain_reg;
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = AW'(bp_eff);
        mem_wr_data    = s_data_byte;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = AW'(rp_reg);
        bp_w           = bp_reg;
        blen_w         = blen_reg;
        ovf_w          = ovf_reg;
        stored_after   = have;

        if (clr) begin
            // capacity change: empty the FIFO and drop any open burst
            wp_next   = '0;
            rp_next   = '0;
            bp_next   = '0;
            blen_next = '0;
            ovf_next  = 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        case (s_operation)
                            OP_PUSH: begin
                                if (!ovf_reg) begin
                                    if (blen_reg >= free_now) begin
                                        ovf_w = 1'b1;
                                    end else begin
                                        mem_wr_en = 1'b1;
                                        bp_w      = adv(bp_eff, cap);
                                        blen_w    = blen_reg + 1'b1;
                                    end
                                end
                                bp_next = bp_w;
                                if (s_burst_last) begin
                                    // commit or reject the whole burst
                                    beat_next.is_data = 1'b0;
                                    beat_next.last    = 1'b1;
                                    if (ovf_w) begin
                                        beat_next.status = ST_REJECT;
                                        beat_next.moved  = '0;
                                    end else begin
                                        wp_next          = bp_w;
                                        beat_next.status = ST_OK;
                                        beat_next.moved  = CNT_W'(blen_w);
                                        stored_after     = have + blen_w;
                                    end
                                    beat_next.stored = CNT_W'(stored_after);
                                    beat_next.free   = CNT_W'(cap - 1'b1 - stored_after);
                                    out_valid_next   = 1'b1;
                                    blen_next        = '0;
                                    ovf_next         = 1'b0;
                                end else begin
                                    blen_next = blen_w;
                                    ovf_next  = ovf_w;
                                end
                            end
                            OP_POP, OP_PEEK: begin
                                out_valid_next = 1'b1;
                                beat_next.status = ST_OK;
                                if (n_rd == '0) begin
                                    beat_next.is_data = 1'b0;
                                    beat_next.last    = 1'b1;
                                    beat_next.moved   = '0;
                                    if (have == '0) begin
                                        beat_next.status = ST_EMPTY;
                                    end
                                    beat_next.stored = CNT_W'(have);
                                    beat_next.free   = CNT_W'(free_now);
                                end else begin
                                    mem_rd_en = 1'b1;
                                    if (s_operation == OP_POP) begin
                                        stored_after = have - n_rd;
                                        rp_next      = PTR_W'(rp_sum);
                                    end
                                    beat_next.is_data = 1'b1;
                                    beat_next.last    = (n_rd == CAP_W'(1));
                                    beat_next.moved   = CNT_W'(n_rd);
                                    beat_next.stored  = CNT_W'(stored_after);
                                    beat_next.free    = CNT_W'(cap - 1'b1 - stored_after);
                                    pos_next    = rp_adv;
                                    remain_next = REQ_W'(n_rd - 1'b1);
                                    if (n_rd != CAP_W'(1)) begin
                                        state_next = S_READ;
                                    end
                                end
                            end
                            default: begin
                                // unused code: drop the beat
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        mem_rd_en      = 1'b1;
                        mem_rd_addr    = AW'(pos_reg);
                        out_valid_next = 1'b1;
                        beat_next.last = (remain_reg == REQ_W'(1));
                        pos_next       = adv(pos_reg, cap);
                        remain_next    = remain_reg - 1'b1;
                        if (remain_reg == REQ_W'(1)) begin
                            state_next = S_IDLE;
                        end
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            bp_reg        <= '0;
            blen_reg      <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            bp_reg        <= bp_next;
            blen_reg      <= blen_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
    end

    assign m_valid = out_valid_reg;
    assign beat    = beat_reg;

    // The FIFO never holds more than one slot short of the capacity.
    a_stored_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        have <= cap - 1'b1)
        else $error("stored count exceeds capacity");

    // Pointers stay inside the slots in use.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CAP_W'(wp_reg) < cap) && (CAP_W'(rp_reg) < cap))
        else $error("pointer outside capacity");

    // A staged burst never claims more room than is free.
    a_burst_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        blen_reg <= free_now)
        else $error("burst staging overruns free space");

    // While streaming read beats, a beat is always held at the output.
    a_read_has_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> out_valid_reg)
        else $error("read sequence without an output beat");

    // The last beat of a read sequence returns the sequencer to idle.
    a_last_ends_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ && out_free && remain_reg == REQ_W'(1))
        |=> (state_reg == S_IDLE && beat_reg.last))
        else $error("read sequence did not close on its last beat");

endmodule

FILE: hw/rtl/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO: capacity register and clamp, controller and byte store.
// Depends on brf_pkg, brf_ctrl and brf_mem.
`timescale 1ns / 1ps

// Circular byte FIFO with a run-time capacity (clamped to 2..DEPTH, at most 127, one
// slot kept empty). A push burst commits or is rejected on its last byte, which yields
// one result beat. A pop or peek of n available bytes yields n beats: the byte store
// has one read port, and the sequencer reads one byte per cycle while the output is
// free, straight into the output register, so the next item is taken when the last
// beat is loaded and the output is free. Empty reads, zero-count reads and push
// results yield one result beat each. Writing the capacity empties the FIFO at once;
// there is no clearing pass, and the store contents are undefined until written.

module byte_ring_fifo_unit
    import brf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_operation,
    input  logic [7:0]       s_data_byte,
    input  logic             s_burst_last,
    input  logic [REQ_W-1:0] s_request_count,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_read_byte,
    output logic             m_result_last,
    output logic [CNT_W-1:0] m_moved_count,
    output logic [1:0]       m_status,
    output logic [CNT_W-1:0] m_stored_count,
    output logic [CNT_W-1:0] m_free_count
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [CAP_W-1:0] CAP_MAX = (DEPTH > 127) ? 7'd127 : CAP_W'(DEPTH);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_eff;
    brf_beat_t        beat;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [7:0]       mem_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign cap_eff = (cap_reg < CAP_MIN) ? CAP_MIN
                   : ((cap_reg > CAP_MAX) ? CAP_MAX : cap_reg);

    brf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cap             (cap_eff),
        .clr             (cfg_wr_en),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_burst_last    (s_burst_last),
        .s_request_count (s_request_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .beat            (beat),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr)
    );

    brf_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // non-data beats carry a zero byte
    assign m_read_byte    = beat.is_data ? mem_rd_data : 8'd0;
    assign m_result_last  = beat.last;
    assign m_moved_count  = beat.moved;
    assign m_status       = beat.status;
    assign m_stored_count = beat.stored;
    assign m_free_count   = beat.free;

endmodule

FILE: test/byte_ring_fifo_unit_checker.sv
// Result checker for the byte ring FIFO: mirrors the FIFO state from the accepted items.
// Predicts every result beat and compares it with the beats the block hands out.
// Depends on brf_pkg.
`timescale 1ns / 1ps

module byte_ring_fifo_unit_checker
    import brf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_operation,
    input  logic [7:0]       s_data_byte,
    input  logic             s_burst_last,
    input  logic [REQ_W-1:0] s_request_count,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [7:0]       m_read_byte,
    input  logic             m_result_last,
    input  logic [CNT_W-1:0] m_moved_count,
    input  logic [1:0]       m_status,
    input  logic [CNT_W-1:0] m_stored_count,
    input  logic [CNT_W-1:0] m_free_count,
    output int               fail_count,
    output int               pending_count
);

    localparam int PTR_W       = $clog2(DEPTH);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0]       read_byte;
        logic             last;
        logic [CNT_W-1:0] moved;
        logic [1:0]       status;
        logic [CNT_W-1:0] stored;
        logic [CNT_W-1:0] free;
    } fifo_beat_t;

    fifo_beat_t       expected_beats[$];
    logic [7:0]       shadow_store[DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] stage_ptr;
    logic [CAP_W-1:0] stage_len;
    logic             stage_overflow;
    logic [CAP_W-1:0] cap_reg;
    int               mismatches = 0;

    function automatic logic [CAP_W-1:0] slots_in_force();
        if (cap_reg < CAP_MIN) return CAP_MIN;
        if (cap_reg > CAP_W'(DEPTH)) return CAP_W'(DEPTH);
        return cap_reg;
    endfunction

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] pos,
                                                   input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] nxt;
        nxt = CAP_W'(pos) + 1'b1;
        return (nxt >= cap) ? '0 : PTR_W'(nxt);
    endfunction

    function automatic logic [CAP_W-1:0] held_bytes();
        logic [CAP_W-1:0] cap;
        cap = slots_in_force();
        if (wr_ptr >= rd_ptr) return CAP_W'(wr_ptr) - CAP_W'(rd_ptr);
        return cap - (CAP_W'(rd_ptr) - CAP_W'(wr_ptr));
    endfunction

    function automatic logic [CAP_W-1:0] room_bytes();
        return slots_in_force() - CAP_W'(1) - held_bytes();
    endfunction

    function automatic void clear_pointers();
        wr_ptr         = '0;
        rd_ptr         = '0;
        stage_ptr      = '0;
        stage_len      = '0;
        stage_overflow = 1'b0;
    endfunction

    // Counts are taken after the item has updated the pointers.
    function automatic fifo_beat_t make_beat(input logic [7:0] rd_byte, input logic last_mark,
                                             input logic [CAP_W-1:0] moved,
                                             input logic [1:0] st);
        fifo_beat_t beat;
        beat.read_byte = rd_byte;
        beat.last      = last_mark;
        beat.moved     = CNT_W'(moved);
        beat.status    = st;
        beat.stored    = CNT_W'(held_bytes());
        beat.free      = CNT_W'(room_bytes());
        return beat;
    endfunction

    function automatic string beat_text(input fifo_beat_t b);
        return $sformatf("byte %02h last %0d moved %0d status %0d stored %0d free %0d",
                         b.read_byte, b.last, b.moved, b.status, b.stored, b.free);
    endfunction

    function automatic void apply_fifo_item(input logic [1:0] op, input logic [7:0] data,
                                            input logic last_mark,
                                            input logic [REQ_W-1:0] want);
        logic [CAP_W-1:0] cap;
        logic [CAP_W-1:0] have;
        logic [CAP_W-1:0] n;
        logic [CAP_W-1:0] i;
        logic [PTR_W-1:0] pos;
        cap = slots_in_force();
        case (op)
            OP_PUSH: begin
                // Stage into the free region; the write pointer moves only on the last byte.
                if (!stage_overflow) begin
                    if (stage_len == '0) stage_ptr = wr_ptr;
                    if (stage_len >= room_bytes()) begin
                        stage_overflow = 1'b1;
                    end else begin
                        shadow_store[stage_ptr] = data;
                        stage_ptr = next_slot(stage_ptr, cap);
                        stage_len = stage_len + 1'b1;
                    end
                end
                if (last_mark) begin
                    if (stage_overflow) begin
                        expected_beats.push_back(make_beat(8'h00, 1'b1, '0, ST_REJECT));
                    end else begin
                        wr_ptr = stage_ptr;
                        expected_beats.push_back(make_beat(8'h00, 1'b1, stage_len, ST_OK));
                    end
                    stage_len      = '0;
                    stage_overflow = 1'b0;
                end
            end
            OP_POP, OP_PEEK: begin
                have = held_bytes();
                n    = (CAP_W'(want) < have) ? CAP_W'(want) : have;
                pos  = rd_ptr;
                if (n == '0) begin
                    expected_beats.push_back(make_beat(8'h00, 1'b1, '0,
                                                       (have == '0) ? ST_EMPTY : ST_OK));
                end else begin
                    if (op == OP_POP) begin
                        for (i = '0; i < n; i = i + 1'b1) rd_ptr = next_slot(rd_ptr, cap);
                    end
                    for (i = '0; i < n; i = i + 1'b1) begin
                        expected_beats.push_back(make_beat(shadow_store[pos],
                                                           (i + 1'b1) == n, n, ST_OK));
                        pos = next_slot(pos, cap);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        fifo_beat_t got;
        fifo_beat_t want;
        if (!aresetn) begin
            cap_reg = CAP_RESET;
            clear_pointers();
            expected_beats.delete();
        end else begin
            // Compare before predicting: a beat handed out now stems from an earlier item.
            if (m_valid && m_ready) begin
                got.read_byte = m_read_byte;
                got.last      = m_result_last;
                got.moved     = m_moved_count;
                got.status    = m_status;
                got.stored    = m_stored_count;
                got.free      = m_free_count;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: %s", beat_text(got));
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result mismatch: expected %s, actual %s",
                                     beat_text(want), beat_text(got));
                    end
                end
            end
            if (cfg_wr_en) begin
                cap_reg = cfg_wr_data;
                clear_pointers();
            end
            if (s_valid && s_ready)
                apply_fifo_item(s_operation, s_data_byte, s_burst_last, s_request_count);
        end
        pending_count <= expected_beats.size();
        fail_count    <= mismatches;
    end

endmodule

FILE: test/byte_ring_fifo_unit_tb.sv
// Testbench top for the byte ring FIFO: clock, reset, stimulus and verdict.
// Depends on brf_pkg, byte_ring_fifo_unit and byte_ring_fifo_unit_checker.
`timescale 1ns / 1ps

module byte_ring_fifo_unit_tb;
    import brf_pkg::*;

    localparam int DEPTH         = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_operation;
    logic [7:0]       s_data_byte;
    logic             s_burst_last;
    logic [REQ_W-1:0] s_request_count;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_read_byte;
    logic             m_result_last;
    logic [CNT_W-1:0] m_moved_count;
    logic [1:0]       m_status;
    logic [CNT_W-1:0] m_stored_count;
    logic [CNT_W-1:0] m_free_count;

    int fail_count;
    int pending_count;
    int fill_level;
    int slots_used;
    bit steady;

    byte_ring_fifo_unit #(.DEPTH(DEPTH)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_burst_last    (s_burst_last),
        .s_request_count (s_request_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_byte     (m_read_byte),
        .m_result_last   (m_result_last),
        .m_moved_count   (m_moved_count),
        .m_status        (m_status),
        .m_stored_count  (m_stored_count),
        .m_free_count    (m_free_count)
    );

    byte_ring_fifo_unit_checker #(.DEPTH(DEPTH)) result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_burst_last    (s_burst_last),
        .s_request_count (s_request_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_byte     (m_read_byte),
        .m_result_last   (m_result_last),
        .m_moved_count   (m_moved_count),
        .m_status        (m_status),
        .m_stored_count  (m_stored_count),
        .m_free_count    (m_free_count),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_count();
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = (fill_level + 2 > 63) ? 63 : fill_level + 2;
        if (r < 20) return 0;
        if (r < 35) return 63;
        return $urandom_range(0, top);
    endfunction

    initial begin : ready_driver
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = pick_gap();
            if (gap == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Raise valid with the payload and hold it until the beat is taken.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] data, input logic last_mark,
                             input logic [REQ_W-1:0] count);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_data_byte     <= data;
        s_burst_last    <= last_mark;
        s_request_count <= count;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_read(input logic [1:0] op, input int count);
        int got;
        send_beat(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), REQ_W'(count));
        if (op == OP_POP) begin
            got = (count < fill_level) ? count : fill_level;
            fill_level -= got;
        end
    endtask

    // A read may be slipped into the middle of the burst; only committed bytes are visible.
    task automatic send_burst(input int len, input bit with_read);
        int room_start;
        int room_after;
        int split;
        int k;
        int got;
        logic [1:0] rd_op;
        logic [REQ_W-1:0] rd_cnt;
        room_start = slots_used - 1 - fill_level;
        room_after = room_start;
        split      = (with_read && len > 1) ? $urandom_range(1, len - 1) : len;
        for (k = 0; k < len; k++) begin
            if (k == split) begin
                rd_op  = $urandom_range(0, 1) ? OP_POP : OP_PEEK;
                rd_cnt = REQ_W'($urandom_range(0, 4));
                send_beat(rd_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rd_cnt);
                if (rd_op == OP_POP) begin
                    got = (rd_cnt < fill_level) ? rd_cnt : fill_level;
                    fill_level -= got;
                    room_after += got;
                end
            end
            send_beat(OP_PUSH, 8'($urandom_range(0, 255)), k == len - 1,
                      REQ_W'($urandom_range(0, 63)));
        end
        if (split <= room_start && len <= room_after) fill_level += len;
    endtask

    // Hold the sender until every expected beat has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        slots_used = (value < CAP_MIN) ? CAP_MIN : (value > DEPTH) ? DEPTH : value;
        fill_level = 0;
    endtask

    task automatic run_random(input int quota);
        int done;
        int r;
        int room;
        int len;
        done = 0;
        while (done < quota) begin
            if ($urandom_range(0, 24) == 0) steady = ~steady;
            room = slots_used - 1 - fill_level;
            r    = $urandom_range(0, 99);
            if (r < 45) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    len = $urandom_range(1, (room > 8) ? 8 : ((room < 1) ? 1 : room));
                else if (r < 75)
                    len = (room < 1) ? 1 : room;
                else if (r < 90)
                    len = room + $urandom_range(1, 3);
                else
                    len = $urandom_range(1, slots_used + 2);
                send_burst(len, $urandom_range(0, 6) == 0);
                done += len;
            end else if (r < 92) begin
                send_read((r < 70) ? OP_POP : OP_PEEK, pick_count());
                done++;
            end else begin
                send_beat(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          REQ_W'($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 29) == 0) drain_results();
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = CAP_RESET;
        s_valid         = 1'b0;
        s_operation     = OP_PUSH;
        s_data_byte     = 8'h00;
        s_burst_last    = 1'b0;
        s_request_count = '0;
        fill_level      = 0;
        slots_used      = DEPTH;
        steady          = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset capacity.
        send_beat(OP_POP,    8'hFF, 1'b1, 6'd63);   // empty read
        send_beat(OP_PEEK,   8'h00, 1'b0, 6'd0);
        send_beat(OP_PUSH,   8'h00, 1'b1, 6'd63);   // one-byte burst
        send_beat(OP_PUSH,   8'hFF, 1'b0, 6'd0);
        send_beat(OP_PUSH,   8'hA5, 1'b0, 6'd0);
        send_beat(OP_PEEK,   8'h5A, 1'b1, 6'd63);   // sees the committed byte only
        send_beat(OP_PUSH,   8'h5A, 1'b1, 6'd0);
        send_beat(OP_PEEK,   8'h00, 1'b0, 6'd0);    // zero request with bytes held
        send_beat(OP_PEEK,   8'h00, 1'b0, 6'd63);   // short read
        send_beat(OP_POP,    8'h00, 1'b0, 6'd2);
        send_beat(OP_UNUSED, 8'hFF, 1'b1, 6'd63);
        send_beat(OP_POP,    8'h00, 1'b0, 6'd63);
        send_beat(OP_POP,    8'h00, 1'b0, 6'd1);

        // Smallest ring: a single byte fits, anything more is rejected.
        write_capacity(CAP_MIN);
        send_beat(OP_PUSH, 8'h11, 1'b1, 6'd0);
        send_beat(OP_PUSH, 8'h22, 1'b0, 6'd0);
        send_beat(OP_PUSH, 8'h33, 1'b1, 6'd0);
        send_beat(OP_POP,  8'h00, 1'b0, 6'd0);
        send_beat(OP_POP,  8'h00, 1'b0, 6'd1);
        send_beat(OP_PUSH, 8'h44, 1'b1, 6'd0);
        send_beat(OP_PUSH, 8'h55, 1'b1, 6'd0);
        send_beat(OP_PEEK, 8'h00, 1'b0, 6'd63);
        send_beat(OP_POP,  8'h00, 1'b0, 6'd63);

        write_capacity(7'd0);
        run_random(20);
        write_capacity(7'd1);
        run_random(20);
        write_capacity(7'd127);
        run_random(60);
        // Leave a burst open; the next capacity write drops it.
        send_beat(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0, REQ_W'($urandom_range(0, 63)));
        send_beat(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0, REQ_W'($urandom_range(0, 63)));
        write_capacity(7'd5);
        run_random(50);
        write_capacity(CAP_RESET);
        run_random(60);
        write_capacity(7'd65);
        run_random(20);
        write_capacity(7'd16);
        run_random(60);
        write_capacity(CAP_W'($urandom_range(3, 20)));
        run_random(40);
        write_capacity(CAP_MIN);
        run_random(30);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
